// File: rtl/length_prefixed_frame_capture_unit_assert.svh
// Assertion macros for the length-prefixed frame capture unit.
// No dependencies; included by the top level. Needs clk and arst_n in scope.
`ifndef LENGTH_PREFIXED_FRAME_CAPTURE_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_CAPTURE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define LPFC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define LPFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LPFC_ASSERT_IMPL(label, ante, cons, msg)
`define LPFC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/lpfc_pkg.sv
// Package for the length-prefixed frame capture unit: item types, codes,
// phase enum and marker table. No dependencies.
package lpfc_pkg;

	localparam int CAPTURE_BYTES_DEF = 32;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	localparam logic [1:0] OP_ARM  = 2'd0;
	localparam logic [1:0] OP_BYTE = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [1:0] STAT_PENDING = 2'd0;
	localparam logic [1:0] STAT_DONE    = 2'd1;
	localparam logic [1:0] STAT_TIMEOUT = 2'd2;

	localparam logic [2:0] MARK_LEN = 3'd5;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MARKER,
		PH_LEN,
		PH_DATA,
		PH_DONE,
		PH_TIMEOUT
	} phase_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] capture_status;
		logic       data_valid;
		logic [7:0] data_byte;
		logic [4:0] data_index;
		logic       frame_last;
		logic [5:0] payload_length;
	} rsp_t;

	// "+IPD," one character per position
	function automatic logic [7:0] mark_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = CH_PLUS;
			3'd1: c = 8'h49;
			3'd2: c = 8'h50;
			3'd3: c = 8'h44;
			3'd4: c = 8'h2C;
			default: c = CH_PLUS;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/lpfc_in_reg.sv
// Input register stage of the frame capture unit.
// Depends on lpfc_pkg (req_t).
module lpfc_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  lpfc_pkg::req_t   req,
	input  logic             advance,
	output logic             valid_s1,
	output lpfc_pkg::req_t   item_s1
);

	logic accept;

	assign req_ready = !valid_s1 || advance;
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
		end
	end

endmodule

// File: rtl/lpfc_engine.sv
// Capture state and per-item update logic: marker hunt, length parse,
// payload indexing and tick countdown. Depends on lpfc_pkg.
module lpfc_engine #(
	parameter int CAPTURE_BYTES = lpfc_pkg::CAPTURE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [15:0]      cfg_wr_data,
	input  logic             fire,
	input  lpfc_pkg::req_t   item_s1,
	output lpfc_pkg::rsp_t   rsp_d
);

	localparam int LW = $clog2(CAPTURE_BYTES + 1);
	localparam int XW = (LW > 6) ? LW : 6;
	localparam logic [LW-1:0] CAP = LW'(CAPTURE_BYTES);

	lpfc_pkg::phase_t phase_q, phase_d;
	logic [2:0]    mpos_q, mpos_d, pos;
	logic [LW-1:0] exp_len_q, exp_len_d;
	logic [LW-1:0] count_q, count_d, count_inc;
	logic [15:0]   ticks_q, ticks_d;
	logic [15:0]   timeout_q;
	logic [LW+3:0] len_acc;
	logic [XW-1:0] count_x, idx_x;
	logic [7:0]    b;
	logic          dvalid, last;

	assign b         = item_s1.rx_byte;
	assign pos       = (mpos_q < lpfc_pkg::MARK_LEN) ? mpos_q : 3'd0;
	// x*10 + digit
	assign len_acc   = ({4'd0, exp_len_q} << 3) + ({4'd0, exp_len_q} << 1)
		+ (LW+4)'(b[3:0]);
	assign count_inc = count_q + LW'(1);

	always_comb begin
		phase_d   = phase_q;
		mpos_d    = mpos_q;
		exp_len_d = exp_len_q;
		count_d   = count_q;
		ticks_d   = ticks_q;
		dvalid    = 1'b0;
		last      = 1'b0;
		unique case (item_s1.opcode)
			lpfc_pkg::OP_ARM: begin
				phase_d   = lpfc_pkg::PH_MARKER;
				mpos_d    = 3'd0;
				exp_len_d = '0;
				count_d   = '0;
				ticks_d   = timeout_q;
			end
			lpfc_pkg::OP_BYTE: begin
				unique case (phase_q)
					lpfc_pkg::PH_MARKER: begin
						if (b == lpfc_pkg::mark_char(pos)) begin
							if (pos + 3'd1 >= lpfc_pkg::MARK_LEN) begin
								phase_d   = lpfc_pkg::PH_LEN;
								exp_len_d = '0;
								mpos_d    = 3'd0;
							end else begin
								mpos_d = pos + 3'd1;
							end
						end else begin
							// a '+' on mismatch restarts the match past its first char
							mpos_d = (b == lpfc_pkg::CH_PLUS) ? 3'd1 : 3'd0;
						end
					end
					lpfc_pkg::PH_LEN: begin
						if (b >= lpfc_pkg::CH_ZERO && b <= lpfc_pkg::CH_NINE) begin
							if (exp_len_q >= CAP || len_acc > (LW+4)'(CAP)) begin
								exp_len_d = CAP;
							end else begin
								exp_len_d = len_acc[LW-1:0];
							end
						end else if (b == lpfc_pkg::CH_COLON) begin
							count_d = '0;
							if (exp_len_q != '0) begin
								phase_d = lpfc_pkg::PH_DATA;
							end else begin
								phase_d = lpfc_pkg::PH_DONE;
								last    = 1'b1;
							end
						end
					end
					lpfc_pkg::PH_DATA: begin
						dvalid  = 1'b1;
						count_d = count_inc;
						if (count_inc >= exp_len_q) begin
							phase_d = lpfc_pkg::PH_DONE;
							last    = 1'b1;
						end
					end
					default: ;
				endcase
			end
			lpfc_pkg::OP_TICK: begin
				if (phase_q == lpfc_pkg::PH_MARKER || phase_q == lpfc_pkg::PH_LEN
						|| phase_q == lpfc_pkg::PH_DATA) begin
					if (ticks_q == 16'd0) begin
						phase_d = lpfc_pkg::PH_TIMEOUT;
					end else begin
						ticks_d = ticks_q - 16'd1;
					end
				end
			end
			default: ;
		endcase
	end

	assign count_x = XW'(count_d);
	assign idx_x   = XW'(count_q);

	always_comb begin
		rsp_d = '0;
		unique case (phase_d)
			lpfc_pkg::PH_DONE:    rsp_d.capture_status = lpfc_pkg::STAT_DONE;
			lpfc_pkg::PH_TIMEOUT: rsp_d.capture_status = lpfc_pkg::STAT_TIMEOUT;
			default:              rsp_d.capture_status = lpfc_pkg::STAT_PENDING;
		endcase
		rsp_d.data_valid     = dvalid;
		rsp_d.data_byte      = dvalid ? b : 8'd0;
		rsp_d.data_index     = dvalid ? idx_x[4:0] : 5'd0;
		rsp_d.frame_last     = last;
		rsp_d.payload_length = count_x[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lpfc_pkg::PH_IDLE;
			mpos_q    <= 3'd0;
			exp_len_q <= '0;
			count_q   <= '0;
			ticks_q   <= 16'd0;
		end else if (fire) begin
			phase_q   <= phase_d;
			mpos_q    <= mpos_d;
			exp_len_q <= exp_len_d;
			count_q   <= count_d;
			ticks_q   <= ticks_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= lpfc_pkg::TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

endmodule

// File: rtl/length_prefixed_frame_capture_unit.sv
// Top level of the length-prefixed frame capture unit: input stage, engine
// and result register. Depends on lpfc_pkg, lpfc_in_reg, lpfc_engine and the assert header.
//
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/ready    | lpfc_pkg::req_t (opcode, rx_byte)
// rsp     | out       | rsp_valid/ready    | lpfc_pkg::rsp_t (status, payload byte)
// cfg     | in        | cfg_wr_en          | cfg_wr_data = timeout_ticks
//
// One item per cycle sustained while rsp is not stalled; an accepted item passes
// through the input register, then the state update feeding the result register.
// Every item gives exactly one result item.
// Reset clears the capture to idle and the timeout back to 1000 ticks.
// A stalled rsp holds its result; req keeps being taken while the input
// register is empty or moving, so one item is buffered behind a stalled result.
module length_prefixed_frame_capture_unit #(
	parameter int CAPTURE_BYTES = lpfc_pkg::CAPTURE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  lpfc_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output lpfc_pkg::rsp_t   rsp,
	input  logic             cfg_wr_en,
	input  logic [15:0]      cfg_wr_data
);

	`include "length_prefixed_frame_capture_unit_assert.svh"

	logic           valid_s1;
	lpfc_pkg::req_t item_s1;
	lpfc_pkg::rsp_t rsp_d;
	lpfc_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;
	logic           advance;
	logic           fire;

	// result register free, or emptied this cycle
	assign advance = !rsp_valid_q || rsp_ready;
	// the held item updates state exactly once, when it moves to the result
	assign fire    = valid_s1 && advance;

	lpfc_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	lpfc_engine #(
		.CAPTURE_BYTES (CAPTURE_BYTES)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.item_s1     (item_s1),
		.rsp_d       (rsp_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a buffered item behind a stalled result must not be dropped
	`LPFC_ASSERT_NEXT(a_hold_s1, valid_s1 && rsp_valid_q && !rsp_ready, valid_s1, "item lost in input stage")
	// the item that completes a frame reports done
	`LPFC_ASSERT_IMPL(a_last_done, rsp_valid_q && rsp_q.frame_last, rsp_q.capture_status == lpfc_pkg::STAT_DONE, "frame_last without done status")
	// a payload byte never comes with a timeout status
	`LPFC_ASSERT_IMPL(a_data_status, rsp_valid_q && rsp_q.data_valid, rsp_q.capture_status != lpfc_pkg::STAT_TIMEOUT, "payload byte with timeout status")

endmodule
